[rtl/core/rbd_pkg.sv]
// ----------------------------------------------------------------------------
// rbd_pkg: shared constants, types and functions of the 2x2 RGB555 downscaler
// Frame geometry, counter widths, the per-channel average and the item
// record passed from the input stage to the output stage.
// ----------------------------------------------------------------------------
package rbd_pkg;

    localparam int SRC_WIDTH   = 256;
    localparam int SRC_HEIGHT  = 224;
    localparam int PIX_W       = 16;
    localparam int STORE_DEPTH = SRC_WIDTH / 2;

    localparam int COL_W  = $clog2(SRC_WIDTH);
    localparam int ROW_W  = $clog2(SRC_HEIGHT);
    localparam int SLOT_W = $clog2(STORE_DEPTH);

    // thumbnail pixels per frame, for the checker's output count
    localparam int THUMB_COUNT = (SRC_WIDTH / 2) * (SRC_HEIGHT / 2);
    localparam int THUMB_W     = $clog2(THUMB_COUNT + 1);

    localparam logic [COL_W-1:0] COL_END  = COL_W'(SRC_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_END  = ROW_W'(SRC_HEIGHT - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'((SRC_WIDTH & ~1) - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'((SRC_HEIGHT & ~1) - 1);
    localparam logic [THUMB_W-1:0] THUMB_LAST = THUMB_W'(THUMB_COUNT - 1);

    localparam logic [PIX_W-1:0] CHANNEL_MASK = 16'h7bde;

    typedef logic [PIX_W-1:0] pix_t;

    // item handed from the input stage to the output stage
    typedef struct packed {
        logic valid;
        pix_t pair;
        logic last;
    } issue_t;

    // floor of the per-channel mean of two RGB555 pixels; bit 15 becomes AND
    function automatic pix_t mean555(input pix_t a, input pix_t b);
        pix_t half_diff;
        half_diff = ((a ^ b) & CHANNEL_MASK) >> 1;
        return (a & b) + half_diff;
    endfunction

endpackage

[rtl/core/rbd_ram.sv]
// ----------------------------------------------------------------------------
// rbd_ram: generic simple dual-port RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module rbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/rbd_front.sv]
// ----------------------------------------------------------------------------
// rbd_front: input stage of the downscaler
// Tracks column and row, holds the first pixel of each pair, averages the
// pair, writes it to the line store on even rows or reads the line store
// and issues an item to the output stage on odd rows.
// ----------------------------------------------------------------------------
module rbd_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  rbd_pkg::pix_t               pixel,
    output logic                        wr_en,
    output logic                        rd_en,
    output logic [rbd_pkg::SLOT_W-1:0]  slot,
    output rbd_pkg::pix_t               pair,
    output rbd_pkg::issue_t             issue
);

    logic [rbd_pkg::COL_W-1:0] col_reg, col_next;
    logic [rbd_pkg::ROW_W-1:0] row_reg, row_next;
    rbd_pkg::pix_t             held_reg, held_next;
    logic [rbd_pkg::COL_W-1:0] col_half;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            held_reg <= held_next;
        end
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        held_next = held_reg;
        if (accept)
        begin
            if (!col_reg[0])
            begin
                held_next = pixel;
            end
            if (col_reg == rbd_pkg::COL_END)
            begin
                col_next = '0;
                row_next = (row_reg == rbd_pkg::ROW_END) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    assign col_half = col_reg >> 1;
    assign slot     = col_half[rbd_pkg::SLOT_W-1:0];
    assign pair     = rbd_pkg::mean555(held_reg, pixel);

    // even rows store the pair average, odd rows fetch the row above
    assign wr_en = accept && col_reg[0] && !row_reg[0];
    assign rd_en = accept && col_reg[0] && row_reg[0];

    always_comb
    begin
        issue.valid = rd_en;
        issue.pair  = pair;
        issue.last  = (row_reg == rbd_pkg::ROW_LAST) && (col_reg == rbd_pkg::COL_LAST);
    end

endmodule

[rtl/core/rbd_back.sv]
// ----------------------------------------------------------------------------
// rbd_back: output stage of the downscaler
// Holds each item in a read stage for the line store read, then averages
// the stored value with the pair average into the output register.
// ----------------------------------------------------------------------------
module rbd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  rbd_pkg::issue_t issue,
    input  rbd_pkg::pix_t   rd_data,
    output logic            take_ok,
    output logic            thumb_valid,
    input  logic            thumb_ready,
    output rbd_pkg::pix_t   thumb_pixel,
    output logic            frame_last
);

    logic          s1_valid_reg, s1_valid_next;
    rbd_pkg::pix_t s1_pair_reg;
    logic          s1_last_reg;
    logic          out_valid_reg, out_valid_next;
    rbd_pkg::pix_t out_pixel_reg;
    logic          out_last_reg;
    logic          out_take;

    assign out_take = !out_valid_reg || thumb_ready;
    assign take_ok  = !s1_valid_reg || out_take;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_take)
        begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (issue.valid)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue.valid)
        begin
            s1_pair_reg <= issue.pair;
            s1_last_reg <= issue.last;
        end
        if (out_take && s1_valid_reg)
        begin
            out_pixel_reg <= rbd_pkg::mean555(rd_data, s1_pair_reg);
            out_last_reg  <= s1_last_reg;
        end
    end

    assign thumb_valid = out_valid_reg;
    assign thumb_pixel = out_pixel_reg;
    assign frame_last  = out_last_reg;

endmodule

[rtl/core/rgb555_box_downscale_2x2.sv]
// ----------------------------------------------------------------------------
// rgb555_box_downscale_2x2: 2x2 box downscaler for an RGB555 pixel stream
// Halves a row-major frame in both directions; each thumbnail pixel is the
// per-channel floor mean of the floored pair averages of a 2x2 source block.
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------
//  source  | pixel_valid / pixel_ready  | pixel[15:0]
//  thumb   | thumb_valid / thumb_ready  | thumb_pixel[15:0], frame_last
//
//  One source item per clock, sustained while pixel_ready is high. A thumbnail
//  item for the source item that completes its 2x2 block passes through the
//  registered line store read and then the output register.
//  Reset clears the column/row counters, the held pixel and both valid flags;
//  the line store is not cleared, every odd row reads what the even row above
//  wrote.
//  A stall on thumb_ready drops pixel_ready only once both the read stage and
//  the output register hold an item.
//
module rgb555_box_downscale_2x2 (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pixel_valid,
    output logic          pixel_ready,
    input  logic [15:0]   pixel,
    output logic          thumb_valid,
    input  logic          thumb_ready,
    output logic [15:0]   thumb_pixel,
    output logic          frame_last
);

    logic                       accept;
    logic                       wr_en;
    logic                       rd_en;
    logic [rbd_pkg::SLOT_W-1:0] slot;
    rbd_pkg::pix_t              pair;
    rbd_pkg::pix_t              rd_data;
    rbd_pkg::issue_t            issue;
    logic                       take_ok;

    assign pixel_ready = take_ok;
    assign accept      = pixel_valid && take_ok;

    // counters, pair average, line store control
    rbd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .pixel  (pixel),
        .wr_en  (wr_en),
        .rd_en  (rd_en),
        .slot   (slot),
        .pair   (pair),
        .issue  (issue)
    );

    // one row of pair averages; read enable freezes the data during stalls
    rbd_ram #(
        .WIDTH (rbd_pkg::PIX_W),
        .DEPTH (rbd_pkg::STORE_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot),
        .wr_data (pair),
        .rd_en   (rd_en),
        .rd_addr (slot),
        .rd_data (rd_data)
    );

    // vertical average and output register
    rbd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (issue),
        .rd_data     (rd_data),
        .take_ok     (take_ok),
        .thumb_valid (thumb_valid),
        .thumb_ready (thumb_ready),
        .thumb_pixel (thumb_pixel),
        .frame_last  (frame_last)
    );

endmodule

[rtl/core/rbd_checker.sv]
// ----------------------------------------------------------------------------
// rbd_checker: port-level checks of the downscaler
// Tracks source position and thumbnail count from the ports and checks
// item accounting, frame_last placement and stall behavior.
// ----------------------------------------------------------------------------
module rbd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pixel_valid,
    input logic        pixel_ready,
    input logic        thumb_valid,
    input logic        thumb_ready,
    input logic [15:0] thumb_pixel,
    input logic        frame_last
);

    logic                          in_acc;
    logic                          out_acc;
    logic                          makes_item;
    logic [rbd_pkg::COL_W-1:0]     col_reg;
    logic [rbd_pkg::ROW_W-1:0]     row_reg;
    logic [1:0]                    pend_reg;
    logic [rbd_pkg::THUMB_W-1:0]   count_reg;

    assign in_acc     = pixel_valid && pixel_ready;
    assign out_acc    = thumb_valid && thumb_ready;
    assign makes_item = in_acc && col_reg[0] && row_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            pend_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                if (col_reg == rbd_pkg::COL_END)
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg == rbd_pkg::ROW_END) ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            pend_reg <= pend_reg + {1'b0, makes_item} - {1'b0, out_acc};
            if (out_acc)
            begin
                count_reg <= (count_reg == rbd_pkg::THUMB_LAST) ? '0 : count_reg + 1'b1;
            end
        end
    end

    // a shown thumbnail item is always backed by a completed 2x2 block
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        thumb_valid |-> (pend_reg != 2'd0))
        else $error("thumbnail item without a completed source block");

    // never more items in flight than the read stage and output register hold
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many thumbnail items in flight");

    // frame_last exactly on the final thumbnail item of a frame
    a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (frame_last == (count_reg == rbd_pkg::THUMB_LAST)))
        else $error("frame_last misplaced");

    // the source side stalls only behind a stalled thumbnail side
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_ready |-> (thumb_valid && !thumb_ready))
        else $error("source stalled without a downstream stall");

    // a stalled thumbnail item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (thumb_valid && !thumb_ready) |=>
            (thumb_valid && $stable(thumb_pixel) && $stable(frame_last)))
        else $error("stalled thumbnail item changed");

endmodule

bind rgb555_box_downscale_2x2 rbd_checker u_rbd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .thumb_valid (thumb_valid),
    .thumb_ready (thumb_ready),
    .thumb_pixel (thumb_pixel),
    .frame_last  (frame_last)
);
